[hdl/afm_pkg.sv]
// Package for the adaptive frequency meter: word types, register indexes,
// controller states, command bundle and the reciprocal table of the divider.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package afm_pkg;

  localparam int unsigned WINDOW_LOG2_DEF = 4;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 33;

  localparam logic [31:0] LOW_DELTA  = 32'd4000;
  localparam logic [31:0] HIGH_DELTA = 32'd40000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROBE_ROLLOVER = 3'd0,
    REG_PROBE_PRESCALE = 3'd1,
    REG_REF_ROLLOVER   = 3'd2,
    REG_REF_PRESCALE   = 3'd3,
    REG_INTERVAL_MAX   = 3'd4,
    REG_ADJUST_DIS     = 3'd5,
    REG_TICKS_PER_SEC  = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL1,
    ST_MUL2,
    ST_DIV1,
    ST_DIV2
  } afm_state_e;

  typedef struct packed {
    logic [31:0] probe_count;
    logic [27:0] ref_count;
  } in_word_t;

  typedef struct packed {
    logic [31:0] probe_delta;
    logic [27:0] probe_freq;
    logic [27:0] ref_hz;
    logic [3:0]  interval_now;
  } out_word_t;

  // One strobe per datapath step.
  typedef struct packed {
    logic ld_in;
    logic upd_sum;
    logic mul1;
    logic mul2;
    logic div1;
    logic div2;
  } afm_cmd_t;

  // floor(2^32 / d) for the interval d; entries 0 and 1 are never used
  // because no division takes place for an interval of one.
  localparam logic [31:0] RECIP_TBL [16] = '{
    32'd0,          32'd0,          32'd2147483648, 32'd1431655765,
    32'd1073741824, 32'd858993459,  32'd715827882,  32'd613566756,
    32'd536870912,  32'd477218588,  32'd429496729,  32'd390451572,
    32'd357913941,  32'd330382099,  32'd306783378,  32'd286331153
  };

endpackage

`default_nettype wire

[hdl/afm_if.sv]
// Valid/ready channel interfaces of the adaptive frequency meter, one for
// sample words and one for result words. Depends on afm_pkg for the payloads.
`timescale 1ns / 1ps
`default_nettype none

interface afm_in_if;
  logic              valid;
  logic              ready;
  afm_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface afm_out_if;
  logic               valid;
  logic               ready;
  afm_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/afm_ctrl.sv]
// Step sequencer of the adaptive frequency meter: walks one sample word
// through the datapath and owns both handshakes. Depends on afm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output afm_pkg::afm_cmd_t      cmd_o
);
  import afm_pkg::*;

  afm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The result register can take a new word when it is empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SUM;
      ST_SUM:  state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_DIV1;
      ST_DIV1: state_d = ST_DIV2;
      ST_DIV2: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.ld_in  = in_valid_i;
      end
      ST_SUM:  cmd_o.upd_sum = 1'b1;
      ST_MUL1: cmd_o.mul1    = 1'b1;
      ST_MUL2: cmd_o.mul2    = 1'b1;
      ST_DIV1: cmd_o.div1    = 1'b1;
      ST_DIV2: cmd_o.div2    = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    if (cmd_o.div2) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hdl/afm_datapath.sv]
// Datapath of the adaptive frequency meter: configuration registers, rollover
// deltas, delta window memory, moving sums, interval adaptation, scaling
// multipliers, reciprocal divider and result register. Depends on afm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afm_datapath #(
  parameter int unsigned WINDOW_LOG2 = afm_pkg::WINDOW_LOG2_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [afm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [afm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire afm_pkg::afm_cmd_t              cmd_i,
  input  wire afm_pkg::in_word_t              in_data_i,
  output afm_pkg::out_word_t                  out_data_o
);
  import afm_pkg::*;

  localparam int unsigned Depth = 2 ** WINDOW_LOG2;
  localparam int unsigned XW    = 32 - WINDOW_LOG2;

  // Only the low 32 bits of a rollover modulus matter, the delta wraps mod 2^32.
  logic [31:0] probe_roll_q, ref_roll_q;
  logic [15:0] pre_q [2];
  logic [3:0]  interval_max_q;
  logic        adjust_dis_q;
  logic [9:0]  tps_q;

  logic [31:0]            probe_last_q;
  logic [27:0]            ref_last_q;
  logic [31:0]            dlt_d [2];
  logic [31:0]            dlt_q [2];
  logic [63:0]            win_mem [Depth];
  logic [63:0]            rd_q;
  logic [Depth-1:0]       win_valid_q;
  logic [WINDOW_LOG2-1:0] slot_q;
  logic [31:0]            old_val [2];
  logic [31:0]            sum_q [2];
  logic [3:0]             interval_q, interval_d;

  logic [47:0]   prod1 [2];
  logic [41:0]   prod2 [2];
  logic [XW+31:0] prod3 [2];
  logic [XW+3:0] prod4 [2];
  logic [XW-1:0] rem [2];
  logic [XW-1:0] quo [2];
  logic [31:0]   hz32 [2];
  logic [31:0]   m1_q [2];
  logic [XW-1:0] x_q [2];
  logic [XW-1:0] qe_q [2];
  logic [31:0]   recip;
  out_word_t     out_q;

  function automatic logic [31:0] wrap_delta(input logic [31:0] now,
                                             input logic [31:0] last,
                                             input logic [31:0] modv);
    logic [31:0] d;
    if (now < last) begin
      d = modv - last + now;
    end else begin
      d = now - last;
    end
    return d;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_roll_q   <= 32'h0000_0000;
      ref_roll_q     <= 32'h1000_0000;
      pre_q[0]       <= 16'd1;
      pre_q[1]       <= 16'd1;
      interval_max_q <= 4'd4;
      adjust_dis_q   <= 1'b0;
      tps_q          <= 10'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PROBE_ROLLOVER: probe_roll_q   <= cfg_data_i[31:0];
        REG_PROBE_PRESCALE: pre_q[0]       <= cfg_data_i[15:0];
        REG_REF_ROLLOVER:   ref_roll_q     <= cfg_data_i[31:0];
        REG_REF_PRESCALE:   pre_q[1]       <= cfg_data_i[15:0];
        REG_INTERVAL_MAX:   interval_max_q <= cfg_data_i[3:0];
        REG_ADJUST_DIS:     adjust_dis_q   <= cfg_data_i[0];
        REG_TICKS_PER_SEC:  tps_q          <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dlt_d[0] = wrap_delta(in_data_i.probe_count, probe_last_q, probe_roll_q);
    dlt_d[1] = wrap_delta({4'b0, in_data_i.ref_count}, {4'b0, ref_last_q}, ref_roll_q);
  end

  // Window memory: one row holds the probe and reference deltas of one slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      rd_q <= win_mem[slot_q];
    end
    if (cmd_i.upd_sum) begin
      win_mem[slot_q] <= {dlt_q[0], dlt_q[1]};
    end
  end

  // A row not yet written reads as zero.
  always_comb begin
    old_val[0] = win_valid_q[slot_q] ? rd_q[63:32] : 32'd0;
    old_val[1] = win_valid_q[slot_q] ? rd_q[31:0]  : 32'd0;
  end

  always_comb begin
    interval_d = interval_q;
    if (!adjust_dis_q) begin
      if (dlt_q[0] < LOW_DELTA && interval_q < interval_max_q) begin
        interval_d = interval_q + 4'd1;
      end else if (dlt_q[0] > HIGH_DELTA && interval_q > 4'd1) begin
        interval_d = interval_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_last_q <= '0;
      ref_last_q   <= '0;
      win_valid_q  <= '0;
      slot_q       <= '0;
      sum_q[0]     <= '0;
      sum_q[1]     <= '0;
      interval_q   <= 4'd1;
    end else begin
      if (cmd_i.ld_in) begin
        probe_last_q <= in_data_i.probe_count;
        ref_last_q   <= in_data_i.ref_count;
      end
      if (cmd_i.upd_sum) begin
        win_valid_q[slot_q] <= 1'b1;
        slot_q              <= slot_q + 1'b1;
        sum_q[0]            <= sum_q[0] - old_val[0] + dlt_q[0];
        sum_q[1]            <= sum_q[1] - old_val[1] + dlt_q[1];
        interval_q          <= interval_d;
      end
    end
  end

  assign recip = RECIP_TBL[interval_q];

  // Two lanes: probe and reference. Each step is one multiply wide.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prod1[l] = sum_q[l] * pre_q[l];
      prod2[l] = m1_q[l] * tps_q;
      prod3[l] = x_q[l] * recip;
      prod4[l] = qe_q[l] * interval_q;
      rem[l]   = x_q[l] - prod4[l][XW-1:0];
      // The reciprocal estimate is low by at most one.
      if (interval_q <= 4'd1) begin
        quo[l] = x_q[l];
      end else if (rem[l] >= XW'(interval_q)) begin
        quo[l] = qe_q[l] + 1'b1;
      end else begin
        quo[l] = qe_q[l];
      end
      hz32[l] = 32'(quo[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd_i.ld_in) begin
        dlt_q[l] <= dlt_d[l];
      end
      if (cmd_i.mul1) begin
        m1_q[l] <= prod1[l][31:0];
      end
      if (cmd_i.mul2) begin
        x_q[l] <= prod2[l][31:WINDOW_LOG2];
      end
      if (cmd_i.div1) begin
        qe_q[l] <= prod3[l][XW+31:32];
      end
    end
    if (cmd_i.div2) begin
      out_q.probe_delta  <= dlt_q[0];
      out_q.probe_freq   <= hz32[0][27:0];
      out_q.ref_hz       <= hz32[1][27:0];
      out_q.interval_now <= interval_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

[hdl/adaptive_frequency_meter.sv]
// Top level of the adaptive frequency meter: joins the step sequencer and
// the datapath. Depends on afm_pkg, afm_if, afm_ctrl and afm_datapath.
//
// Use: each word on in_i is one sampling event with snapshots of the probe
// and reference counters. For each word one result word leaves on out_o with
// the rollover-corrected probe delta, both moving-average frequencies in Hz
// divided by the sampling interval, and the interval after adaptation.
// Both channels move a word when valid and ready are high at a clock edge.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i
// while the block is idle; unknown indexes are ignored.
// A result word becomes valid in the result register once its sample has
// gone through the six steps of the sequencer (window read, sum update, two
// scaling multiplies and the two steps of the reciprocal divider). A new
// sample is taken only after the last one has left its final step.
// When the receiver stalls, the finished word waits in the result register
// and the next sample is still taken and worked on; it holds in its last
// step until the result register frees up.
// Reset clears the previous snapshots, the moving sums, the window (through
// one valid bit per row, no clearing pass), sets the interval to one and
// loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_frequency_meter #(
  parameter int unsigned WINDOW_LOG2 = afm_pkg::WINDOW_LOG2_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [afm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [afm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  afm_in_if.sink                              in_i,
  afm_out_if.source                           out_o
);
  import afm_pkg::*;

  afm_cmd_t cmd;

  // The sequencer handles both handshakes; the datapath only sees steps.
  afm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  afm_datapath #(
    .WINDOW_LOG2 (WINDOW_LOG2)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .in_data_i   (in_i.data),
    .out_data_o  (out_o.data)
  );

`ifndef SYNTHESIS
  // A taken sample keeps the input closed while it is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("sample taken while the previous one is in flight");

  // Interval adaptation never lets the interval reach zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.interval_now != 4'd0))
    else $error("result word carries a zero interval");

  // A new result word only appears after a sample went through the steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result word appeared without a sample in flight");
`endif

endmodule

`default_nettype wire

[test/afm_scoreboard.sv]
// Result checker for the adaptive frequency meter: watches the register port
// and both word channels, predicts each result word and compares it.
// Depends on afm_pkg for the word types and register indexes, and on afm_if.
`timescale 1ns / 1ps

module afm_scoreboard (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [afm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [afm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  afm_in_if                              in_i,
  afm_out_if                             out_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    words_pending_o
);
  import afm_pkg::*;

  localparam int unsigned HIST_LOG2  = WINDOW_LOG2_DEF;
  localparam int unsigned HIST_DEPTH = 1 << HIST_LOG2;
  localparam int unsigned SHOWN_MAX  = 10;

  // Register copies.
  logic [32:0] probe_wrap;
  logic [15:0] probe_scale;
  logic [32:0] ref_wrap;
  logic [15:0] ref_scale;
  logic [3:0]  interval_limit;
  logic        hold_interval;
  logic [9:0]  tick_rate;

  // Meter state.
  logic [31:0]          probe_prev;
  logic [27:0]          ref_prev;
  logic [31:0]          probe_hist [HIST_DEPTH];
  logic [31:0]          ref_hist [HIST_DEPTH];
  logic [31:0]          probe_total;
  logic [31:0]          ref_total;
  logic [HIST_LOG2-1:0] hist_slot;
  logic [3:0]           cur_interval;

  out_word_t expected_words [$];

  // A snapshot below the previous one means the counter wrapped at its modulus.
  function automatic logic [31:0] count_delta(logic [31:0] now, logic [31:0] prev,
                                              logic [32:0] modulus);
    logic [63:0] span;
    if (now < prev) span = 64'(modulus) - 64'(prev) + 64'(now);
    else span = 64'(now) - 64'(prev);
    return span[31:0];
  endfunction

  // The scaling product keeps only its low 32 bits before the average shift.
  function automatic logic [27:0] scaled_hz(logic [31:0] total, logic [15:0] scale,
                                            logic [9:0] rate, logic [3:0] ivl);
    logic [63:0] prod;
    logic [31:0] avg;
    prod = 64'(total) * 64'(scale) * 64'(rate);
    avg  = prod[31:0] >> HIST_LOG2;
    if (ivl > 4'd1) avg = avg / {28'd0, ivl};
    return avg[27:0];
  endfunction

  task automatic clear_meter();
    probe_wrap     = 33'h1_0000_0000;
    probe_scale    = 16'd1;
    ref_wrap       = 33'h0_1000_0000;
    ref_scale      = 16'd1;
    interval_limit = 4'd4;
    hold_interval  = 1'b0;
    tick_rate      = 10'd100;
    probe_prev     = '0;
    ref_prev       = '0;
    probe_total    = '0;
    ref_total      = '0;
    hist_slot      = '0;
    cur_interval   = 4'd1;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      probe_hist[i] = '0;
      ref_hist[i]   = '0;
    end
  endtask

  task automatic load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_PROBE_ROLLOVER: probe_wrap = value;
      REG_PROBE_PRESCALE: probe_scale = value[15:0];
      REG_REF_ROLLOVER:   ref_wrap = value;
      REG_REF_PRESCALE:   ref_scale = value[15:0];
      REG_INTERVAL_MAX:   interval_limit = value[3:0];
      REG_ADJUST_DIS:     hold_interval = value[0];
      REG_TICKS_PER_SEC:  tick_rate = value[9:0];
      default: ;
    endcase
  endtask

  task automatic take_sample(in_word_t w);
    out_word_t   want;
    logic [31:0] pd;
    logic [31:0] rd;
    pd = count_delta(w.probe_count, probe_prev, probe_wrap);
    rd = count_delta({4'd0, w.ref_count}, {4'd0, ref_prev}, ref_wrap);
    probe_prev = w.probe_count;
    ref_prev   = w.ref_count;
    probe_total = probe_total - probe_hist[hist_slot] + pd;
    ref_total   = ref_total - ref_hist[hist_slot] + rd;
    probe_hist[hist_slot] = pd;
    ref_hist[hist_slot]   = rd;
    hist_slot = hist_slot + 1'b1;
    if (!hold_interval) begin
      if (pd < LOW_DELTA && cur_interval < interval_limit) cur_interval = cur_interval + 1'b1;
      else if (pd > HIGH_DELTA && cur_interval > 4'd1) cur_interval = cur_interval - 1'b1;
    end
    want.probe_delta  = pd;
    want.probe_freq   = scaled_hz(probe_total, probe_scale, tick_rate, cur_interval);
    want.ref_hz       = scaled_hz(ref_total, ref_scale, tick_rate, cur_interval);
    want.interval_now = cur_interval;
    expected_words.push_back(want);
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      mismatch_count_o++;
      if (mismatch_count_o <= SHOWN_MAX)
        $display("[%0t] result word with none expected: delta=%0d hz=%0d ref_hz=%0d ivl=%0d",
                 $time, got.probe_delta, got.probe_freq, got.ref_hz, got.interval_now);
    end else begin
      want = expected_words.pop_front();
      if (got.probe_delta !== want.probe_delta || got.probe_freq !== want.probe_freq ||
          got.ref_hz !== want.ref_hz || got.interval_now !== want.interval_now) begin
        mismatch_count_o++;
        if (mismatch_count_o <= SHOWN_MAX)
          $display("[%0t] expected delta=%0d hz=%0d ref_hz=%0d ivl=%0d, got %0d %0d %0d %0d",
                   $time, want.probe_delta, want.probe_freq, want.ref_hz, want.interval_now,
                   got.probe_delta, got.probe_freq, got.ref_hz, got.interval_now);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_meter();
      expected_words.delete();
    end else begin
      if (cfg_we_i) load_reg(cfg_index_i, cfg_data_i);
      if (in_i.valid && in_i.ready) take_sample(in_i.data);
      if (out_i.valid && out_i.ready) check_word(out_i.data);
    end
    words_pending_o = expected_words.size();
  end

endmodule

[test/adaptive_frequency_meter_tb.sv]
// Testbench top for the adaptive frequency meter: clock, reset, register
// writes, sample words and receiver stalls, and the final verdict.
// Depends on afm_pkg, afm_if, the block itself and afm_scoreboard.
`timescale 1ns / 1ps

module adaptive_frequency_meter_tb;
  import afm_pkg::*;

  // Longest stretch without any accepted word before the run is declared hung.
  // A correct run stays far below it, its longest quiet stretch being a sender
  // gap, a receiver stall, six sequencer steps and a handful of register writes.
  localparam int unsigned STALL_LIMIT    = 2000;
  // Cycles of quiet after the last result word, well past the block latency.
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned WORDS_PER_PHASE = 53;
  // An index that names no register; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  afm_in_if  in_ch ();
  afm_out_if out_ch ();

  int unsigned mismatch_count;
  int unsigned words_pending;
  int unsigned quiet_cycles = 0;
  logic        in_taken;
  logic        gaps_on = 1'b1;
  int unsigned small_pct = 40;

  // Last snapshots sent, so that most random samples move forward from them.
  logic [31:0] probe_snap = '0;
  logic [27:0] ref_snap = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  adaptive_frequency_meter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  afm_scoreboard scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_i             (in_ch),
    .out_i            (out_ch),
    .mismatch_count_o (mismatch_count),
    .words_pending_o  (words_pending)
  );

  // The handshake is registered here at the rising edge, so the sender, which
  // works at the falling edge, never races the block's own ready update.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: ready drops at random while gaps are on, so that result words
  // wait in the block's result register at every step of the following
  // sample's work.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (gaps_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Presents one sample word, maybe after a short gap, and returns at the
  // falling edge after it was taken. Valid stays high on return, so the caller
  // either presents the next word or lowers valid in that same step.
  task automatic send_sample(input logic [31:0] probe, input logic [27:0] refc);
    in_word_t w;
    w.probe_count = probe;
    w.ref_count   = refc;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_ch.data  <= w;
    in_ch.valid <= 1'b1;
    do @(negedge clk_i); while (!in_taken);
    probe_snap = probe;
    ref_snap   = refc;
  endtask

  // Most samples step the counters forward by a delta from one of the bands
  // that drive the interval: below the grow threshold, between the two, above
  // the shrink threshold, or right at either threshold. Now and then a
  // snapshot jumps to an arbitrary value, which often looks like a rollover.
  task automatic send_random_sample();
    logic [31:0] step;
    logic [31:0] probe;
    logic [27:0] refc;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < small_pct) begin
      step = $urandom_range(0, LOW_DELTA - 1);
    end else if (pick < small_pct + (100 - small_pct) / 4) begin
      step = $urandom_range(LOW_DELTA, HIGH_DELTA);
    end else if (pick < small_pct + (100 - small_pct) / 2) begin
      step = ($urandom_range(0, 1) ? LOW_DELTA : HIGH_DELTA) + $urandom_range(0, 2) - 1;
    end else if (pick < 95) begin
      step = $urandom_range(HIGH_DELTA + 1, 1 << 22);
    end else begin
      step = $urandom;
    end
    probe = probe_snap + step;
    if ($urandom_range(0, 19) == 0) probe = $urandom;
    if ($urandom_range(0, 19) == 0) refc = 28'($urandom);
    else refc = ref_snap + 28'($urandom_range(0, 1 << 20));
    send_sample(probe, refc);
  endtask

  // Lowers valid and waits until every expected result word has come back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk_i);
  endtask

  function automatic logic [32:0] pick_rollover();
    case ($urandom_range(0, 3))
      0: return 33'h1_0000_0000;
      1: return 33'h0_1000_0000;
      2: return 33'($urandom_range(1, 1000));
      default: return {1'($urandom_range(0, 1)), 32'($urandom)};
    endcase
  endfunction

  // Register settings of each phase. The first phases visit the extremes:
  // the largest moduli and scales, a zero probe modulus, scale and tick rate
  // with a zero maximum that stops the interval from growing, a zero reference
  // modulus and scale with a frozen interval, and a maximum lowered below an
  // interval that earlier phases may have raised. The rest draw random settings.
  task automatic configure_phase(input int unsigned phase_no);
    logic [32:0] pr;
    logic [15:0] pp;
    logic [32:0] rr;
    logic [15:0] rp;
    logic [3:0]  imax;
    logic        adj;
    logic [9:0]  tps;
    case (phase_no)
      1: begin
        pr = 33'h1_FFFF_FFFF; pp = 16'hFFFF; rr = 33'h1_FFFF_FFFF; rp = 16'hFFFF;
        imax = 4'd15; adj = 1'b0; tps = 10'd1000;
      end
      2: begin
        pr = '0; pp = '0; rr = 33'd1; rp = 16'd1;
        imax = 4'd0; adj = 1'b0; tps = '0;
      end
      3: begin
        pr = 33'd1; pp = 16'd1; rr = '0; rp = '0;
        imax = 4'd1; adj = 1'b1; tps = 10'd1;
      end
      4: begin
        pr = 33'h1_0000_0000; pp = 16'($urandom); rr = 33'h0_1000_0000; rp = 16'($urandom);
        imax = 4'd2; adj = 1'b0; tps = 10'($urandom);
      end
      default: begin
        pr = pick_rollover(); pp = 16'($urandom); rr = pick_rollover(); rp = 16'($urandom);
        imax = 4'($urandom); adj = ($urandom_range(0, 3) == 0); tps = 10'($urandom);
      end
    endcase
    write_reg(REG_PROBE_ROLLOVER, pr);
    write_reg(REG_PROBE_PRESCALE, 33'(pp));
    write_reg(REG_REF_ROLLOVER, rr);
    write_reg(REG_REF_PRESCALE, 33'(rp));
    write_reg(REG_INTERVAL_MAX, 33'(imax));
    write_reg(REG_ADJUST_DIS, 33'(adj));
    write_reg(REG_TICKS_PER_SEC, 33'(tps));
    if (phase_no == 2) write_reg(UNUSED_REG, {1'b1, 32'($urandom)});
    cfg_we <= 1'b0;
  endtask

  // Directed words under the reset settings: the first sample is taken whole,
  // the interval climbs to its maximum and stays there, deltas sit exactly on
  // both thresholds and one past them, both counters hit all ones and then
  // roll over, and enough samples follow to wrap the averaging window.
  task automatic run_directed();
    send_sample(32'h0001_2345, 28'h00A_BCDE);
    send_sample(probe_snap, ref_snap);
    send_sample(probe_snap + 1, ref_snap + 1);
    send_sample(probe_snap + LOW_DELTA - 1, ref_snap + 28'd100);
    send_sample(probe_snap + 100, ref_snap);
    send_sample(probe_snap + LOW_DELTA, ref_snap + 28'd5000);
    send_sample(probe_snap + HIGH_DELTA, ref_snap + 28'd50000);
    send_sample(probe_snap + HIGH_DELTA + 1, ref_snap + 28'd1);
    send_sample(32'hFFFF_FFFF, 28'hFFF_FFFF);
    send_sample(32'h0000_0010, 28'h000_0000);
    send_sample(32'h0000_0000, 28'h000_0000);
    send_sample(32'hFFFF_FFFF, 28'hFFF_FFFF);
    send_sample(32'hAAAA_AAAA, 28'h555_5555);
    send_sample(32'h5555_5555, 28'hAAA_AAAA);
    for (int i = 0; i < 8; i++) send_sample(probe_snap + 17, ref_snap + 28'd3);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    wait_idle();

    for (int unsigned ph = 1; ph <= RANDOM_PHASES; ph++) begin
      configure_phase(ph);
      // The last phase runs with no gaps on either side; the others mostly
      // idle, with the odd phase left clean for long back-to-back stretches.
      gaps_on   = (ph != RANDOM_PHASES) && ($urandom_range(0, 3) != 0);
      small_pct = (ph == 1) ? 85 : $urandom_range(20, 70);
      for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) send_random_sample();
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
